// ===== rtl/core/roi_pixel_histogram_stats_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the region-of-interest histogram block
// Immediate-implication and next-cycle-implication property forms.
// ---------------------------------------------------------------------------
`ifndef ROI_PIXEL_HISTOGRAM_STATS_TOP_ASSERT_SVH
`define ROI_PIXEL_HISTOGRAM_STATS_TOP_ASSERT_SVH

// same-cycle implication
`define RPH_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("roi histogram check failed");

// next-cycle implication
`define RPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("roi histogram check failed");

`endif

// ===== rtl/core/roi_hist_pkg.sv =====
// ---------------------------------------------------------------------------
// roi_hist_pkg
// Shared types, codes and defaults of the region-of-interest histogram.
// ---------------------------------------------------------------------------
package roi_hist_pkg;

    localparam int DEF_BIN_COUNT   = 256;
    localparam int DEF_COUNT_WIDTH = 24;
    localparam int COORD_W         = 12;
    localparam int CFG_DATA_W      = 12;
    localparam int CFG_INDEX_W     = 3;
    localparam int NUM_CHAN        = 3;
    localparam int DEV_W           = 64;

    localparam logic [COORD_W-1:0] RST_X_END = COORD_W'(1920);
    localparam logic [COORD_W-1:0] RST_Y_END = COORD_W'(1080);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_PIXEL  = 2'd1,
        CMD_REPORT = 2'd2
    } t_command;

    typedef enum logic [1:0] {
        MODE_RAW        = 2'd0,
        MODE_RGBA_MONO  = 2'd1,
        MODE_BAYER      = 2'd2,
        MODE_RGBA_COLOR = 2'd3
    } t_mode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE    = 3'd0,
        CFG_X_START = 3'd1,
        CFG_Y_START = 3'd2,
        CFG_X_END   = 3'd3,
        CFG_Y_END   = 3'd4
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_RGO,
        ST_ROOT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        RT_IDLE,
        RT_DIV,
        RT_SQRT
    } t_root_state;

    typedef struct packed {
        logic [1:0]         command;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [7:0]         byte_zero;
        logic [7:0]         byte_one;
        logic [7:0]         byte_two;
    } t_request;

    typedef struct packed {
        logic [1:0]  channel;
        logic [7:0]  median_bin;
        logic [15:0] spread_q8;
        logic [7:0]  lowest_bin;
        logic [7:0]  highest_bin;
        logic [23:0] dark_count;
        logic [23:0] saturated_count;
        logic        empty_res;
        logic        last;
    } t_result;

endpackage

// ===== rtl/core/roi_hist_mem.sv =====
// ---------------------------------------------------------------------------
// roi_hist_mem
// One histogram bin store: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module roi_hist_mem #(
    parameter int DEPTH = roi_hist_pkg::DEF_BIN_COUNT,
    parameter int WIDTH = roi_hist_pkg::DEF_COUNT_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import roi_hist_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/roi_hist_root.sv =====
// ---------------------------------------------------------------------------
// roi_hist_root
// Mean deviation divide and Q8.8 square root, one bit per cycle.
// ---------------------------------------------------------------------------
module roi_hist_root #(
    parameter int TOTAL_W = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  logic [roi_hist_pkg::DEV_W-1:0] i_dev,
    input  logic [TOTAL_W-1:0]             i_total,
    output logic                           o_done,
    output logic [15:0]                    o_spread
);
    import roi_hist_pkg::*;

    localparam int DIV_W = TOTAL_W + 16;
    localparam int CMP_W = (DIV_W > DEV_W) ? DIV_W + 1 : DEV_W + 1;

    t_root_state      r_state;
    logic [3:0]       r_step;
    logic [DEV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [15:0]      r_quo;
    logic [15:0]      r_res;
    logic             r_done;

    logic             sat;
    logic             fits;
    logic [15:0]      trial;
    logic [31:0]      sq;

    always_comb begin
        sat   = CMP_W'(i_dev) >= CMP_W'({i_total, 16'd0});
        fits  = CMP_W'(r_rem) >= CMP_W'(r_div);
        trial = r_res | (16'd1 << r_step);
        sq    = 32'(trial) * 32'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RT_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                RT_IDLE: begin
                    if (i_go) begin
                        if (sat) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= RT_DIV;
                        end
                    end
                end
                RT_DIV: begin
                    if (r_step == 4'd0) begin
                        r_state <= RT_SQRT;
                    end
                end
                RT_SQRT: begin
                    if (r_step == 4'd0) begin
                        r_state <= RT_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= RT_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            RT_IDLE: begin
                r_step <= 4'd15;
                r_rem  <= i_dev;
                r_div  <= DIV_W'({i_total, 15'd0});
                r_quo  <= '0;
                r_res  <= sat ? 16'hFFFF : 16'd0;
            end
            RT_DIV: begin
                if (fits) begin
                    r_rem <= r_rem - DEV_W'(r_div);
                end
                r_quo  <= {r_quo[14:0], fits};
                r_div  <= r_div >> 1;
                r_step <= r_step - 4'd1;
            end
            RT_SQRT: begin
                if (sq <= {r_quo, 16'd0}) begin
                    r_res <= trial;
                end
                r_step <= r_step - 4'd1;
            end
            default: r_step <= 4'd15;
        endcase
    end

    assign o_done   = r_done;
    assign o_spread = r_res;

endmodule

// ===== rtl/core/roi_pixel_histogram_stats_top.sv =====
// ---------------------------------------------------------------------------
// roi_pixel_histogram_stats_top
// Region-of-interest pixel histograms with median and spread reporting.
// ---------------------------------------------------------------------------
// After reset the block sweeps all three bin memories to zero with busy
// high, and does the same for a clear request. A pixel request holds busy
// for a read, then a write back of each bin update into the
// single-port-per-side bin memory: one update in raw and Bayer modes,
// three in the two RGBA byte modes; a pixel outside the region leaves busy low.
// A report request walks each histogram three times through the memory
// read port (totals and extremes, median, deviation sum), then divides and
// takes the root one bit per cycle; an empty histogram ends after the first
// walk, and a saturated spread skips the divide and the root. Each result
// appears on o_result for exactly one cycle with o_done high and must be
// taken then.
// ---------------------------------------------------------------------------
module roi_pixel_histogram_stats_top #(
    parameter int BIN_COUNT   = roi_hist_pkg::DEF_BIN_COUNT,
    parameter int COUNT_WIDTH = roi_hist_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  roi_hist_pkg::t_request                i_request,
    output logic                                  o_done,
    output roi_hist_pkg::t_result                 o_result,
    input  logic                                  i_cfg_we,
    input  logic [roi_hist_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [roi_hist_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import roi_hist_pkg::*;

    localparam int BIN_W   = $clog2(BIN_COUNT);
    localparam int CNT_W   = BIN_W + 1;
    localparam int TOTAL_W = COUNT_WIDTH + BIN_W;
    localparam int PROD_W  = COUNT_WIDTH + 2 * BIN_W;
    localparam logic [BIN_W-1:0] LAST_IDX = BIN_W'(BIN_COUNT - 1);
    localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(BIN_COUNT);

    t_state r_state, n_state;

    t_mode              r_mode;
    logic [COORD_W-1:0] r_xs, r_ys, r_xe, r_ye;

    t_request           r_req;
    logic [1:0]         r_slot;
    logic [1:0]         r_tgt;
    logic [BIN_W-1:0]   r_baddr;
    logic [1:0]         r_chan;
    logic [1:0]         r_last_chan;

    logic [CNT_W-1:0]   r_cnt;
    logic               r_s1_vld;
    logic [BIN_W-1:0]   r_s1_idx;
    logic [2*BIN_W-1:0] r_s1_dsq;
    logic               r_s2_vld;
    logic               r_s2_last;
    logic [DEV_W-1:0]   r_s2_term;

    logic [TOTAL_W-1:0]     r_total;
    logic [TOTAL_W-1:0]     r_run;
    logic [BIN_W-1:0]       r_lo, r_hi, r_med;
    logic                   r_lo_found, r_med_found;
    logic [COUNT_WIDTH-1:0] r_bin0, r_binl;
    logic [DEV_W-1:0]       r_dev;
    logic [15:0]            r_spread;
    logic                   r_empty;

    logic                   mem_we [NUM_CHAN];
    logic [BIN_W-1:0]       mem_waddr, mem_raddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [COUNT_WIDTH-1:0] mem_rdata [NUM_CHAN];

    logic                   accept;
    logic                   raw;
    logic [COORD_W-1:0]     xs_a, ys_a, xe_a, ye_a;
    logic [COORD_W:0]       margin;
    logic                   in_roi;
    logic [1:0]             tgt;
    logic [7:0]             bval;
    logic [BIN_W-1:0]       pix_addr;
    logic                   more;
    logic                   iss;
    logic                   in_pass;
    logic                   s1_last;
    logic [COUNT_WIDTH-1:0] rep_data;
    logic [COUNT_WIDTH-1:0] pix_data;
    logic [TOTAL_W-1:0]     total_n, run_n;
    logic [BIN_W-1:0]       bin_dist;
    logic [PROD_W-1:0]      prod;
    logic [DEV_W:0]         dev_sum;
    logic                   root_go, root_done;
    logic [15:0]            root_spread;

    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_bins
        roi_hist_mem #(
            .DEPTH (BIN_COUNT),
            .WIDTH (COUNT_WIDTH)
        ) u_mem (
            .i_clk   (i_clk),
            .i_we    (mem_we[g]),
            .i_waddr (mem_waddr),
            .i_wdata (mem_wdata),
            .i_raddr (mem_raddr),
            .o_rdata (mem_rdata[g])
        );
    end

    roi_hist_root #(
        .TOTAL_W (TOTAL_W)
    ) u_root (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (root_go),
        .i_dev    (r_dev),
        .i_total  (r_total),
        .o_done   (root_done),
        .o_spread (root_spread)
    );

    always_comb begin
        accept = start && (r_state == ST_IDLE);
        raw    = (r_mode == MODE_RAW);
        xs_a   = raw ? r_xs : {r_xs[COORD_W-1:1], 1'b0};
        ys_a   = raw ? r_ys : {r_ys[COORD_W-1:1], 1'b0};
        xe_a   = raw ? r_xe : {r_xe[COORD_W-1:1], 1'b0};
        ye_a   = raw ? r_ye : {r_ye[COORD_W-1:1], 1'b0};
        margin = raw ? (COORD_W+1)'(1) : (COORD_W+1)'(2);
        in_roi = (i_request.pixel_x >= xs_a)
              && (({1'b0, i_request.pixel_x} + margin) < {1'b0, xe_a})
              && (i_request.pixel_y >= ys_a)
              && (({1'b0, i_request.pixel_y} + margin) < {1'b0, ye_a});
    end

    always_comb begin
        unique case (r_slot)
            2'd0:    bval = r_req.byte_zero;
            2'd1:    bval = r_req.byte_one;
            default: bval = r_req.byte_two;
        endcase
        unique case (r_mode)
            MODE_RAW: begin
                tgt  = 2'd0;
                bval = r_req.byte_zero;
            end
            MODE_RGBA_MONO: begin
                tgt = 2'd0;
            end
            MODE_BAYER: begin
                bval = r_req.byte_zero;
                if (!r_req.pixel_x[0] && !r_req.pixel_y[0]) begin
                    tgt = 2'd0;
                end else if (r_req.pixel_x[0] && r_req.pixel_y[0]) begin
                    tgt = 2'd2;
                end else begin
                    tgt = 2'd1;
                end
            end
            MODE_RGBA_COLOR: begin
                tgt = r_slot;
            end
            default: tgt = 2'd0;
        endcase
        if (32'(bval) >= BIN_COUNT) begin
            pix_addr = LAST_IDX;
        end else begin
            pix_addr = BIN_W'(bval);
        end
        more = ((r_mode == MODE_RGBA_MONO) || (r_mode == MODE_RGBA_COLOR))
            && (r_slot != 2'd2);
    end

    always_comb begin
        iss      = (r_cnt < END_CNT);
        in_pass  = (r_state == ST_P1) || (r_state == ST_P2) || (r_state == ST_P3);
        s1_last  = r_s1_vld && (r_s1_idx == LAST_IDX);
        rep_data = mem_rdata[r_chan];
        pix_data = mem_rdata[r_tgt];
        total_n  = r_total + TOTAL_W'(rep_data);
        run_n    = r_run + TOTAL_W'(rep_data);
        bin_dist = (r_cnt[BIN_W-1:0] >= r_med) ? r_cnt[BIN_W-1:0] - r_med
                                               : r_med - r_cnt[BIN_W-1:0];
        prod     = PROD_W'(rep_data) * PROD_W'(r_s1_dsq);
        dev_sum  = {1'b0, r_dev} + {1'b0, r_s2_term};
    end

    always_comb begin
        n_state   = r_state;
        root_go   = 1'b0;
        o_done    = 1'b0;
        mem_waddr = r_cnt[BIN_W-1:0];
        mem_raddr = r_cnt[BIN_W-1:0];
        mem_wdata = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            mem_we[c] = 1'b0;
        end
        unique case (r_state)
            ST_INIT, ST_CLR: begin
                for (int c = 0; c < NUM_CHAN; c++) begin
                    mem_we[c] = 1'b1;
                end
                if (r_cnt == CNT_W'(BIN_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_request.command)
                        CMD_CLEAR:  n_state = ST_CLR;
                        CMD_PIXEL:  n_state = in_roi ? ST_PIX_RD : ST_IDLE;
                        CMD_REPORT: n_state = ST_P1;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_RD: begin
                mem_raddr = pix_addr;
                n_state   = ST_PIX_WR;
            end
            ST_PIX_WR: begin
                mem_waddr = r_baddr;
                mem_wdata = (&pix_data) ? pix_data : pix_data + COUNT_WIDTH'(1);
                for (int c = 0; c < NUM_CHAN; c++) begin
                    mem_we[c] = (r_tgt == 2'(c));
                end
                n_state = more ? ST_PIX_RD : ST_IDLE;
            end
            ST_P1: begin
                if (s1_last) begin
                    n_state = (total_n == '0) ? ST_OUT : ST_P2;
                end
            end
            ST_P2: begin
                if (s1_last) begin
                    n_state = ST_P3;
                end
            end
            ST_P3: begin
                if (r_s2_vld && r_s2_last) begin
                    n_state = ST_RGO;
                end
            end
            ST_RGO: begin
                root_go = 1'b1;
                n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (root_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_done  = 1'b1;
                n_state = (r_chan == r_last_chan) ? ST_IDLE : ST_P1;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_cnt    <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_mode   <= MODE_RAW;
            r_xs     <= '0;
            r_ys     <= '0;
            r_xe     <= RST_X_END;
            r_ye     <= RST_Y_END;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else if ((r_state == ST_INIT) || (r_state == ST_CLR)
                         || (in_pass && iss)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            r_s1_vld <= in_pass && iss && (n_state == r_state);
            r_s2_vld <= (r_state == ST_P3) && r_s1_vld;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:    r_mode <= t_mode'(i_cfg_data[1:0]);
                    CFG_X_START: r_xs   <= i_cfg_data;
                    CFG_Y_START: r_ys   <= i_cfg_data;
                    CFG_X_END:   r_xe   <= i_cfg_data;
                    CFG_Y_END:   r_ye   <= i_cfg_data;
                    default:     r_mode <= r_mode;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= r_cnt[BIN_W-1:0];
        r_s1_dsq  <= (2*BIN_W)'(bin_dist) * (2*BIN_W)'(bin_dist);
        r_s2_term <= DEV_W'(prod);
        r_s2_last <= (r_s1_idx == LAST_IDX);

        if (accept) begin
            r_req       <= i_request;
            r_slot      <= 2'd0;
            r_chan      <= 2'd0;
            r_last_chan <= ((r_mode == MODE_RAW) || (r_mode == MODE_RGBA_MONO))
                           ? 2'd0 : 2'd2;
        end
        if (r_state == ST_PIX_RD) begin
            r_tgt   <= tgt;
            r_baddr <= pix_addr;
        end
        if (r_state == ST_PIX_WR) begin
            r_slot <= r_slot + 2'd1;
        end

        if ((n_state == ST_P1) && (r_state != ST_P1)) begin
            r_total    <= '0;
            r_lo       <= '0;
            r_hi       <= '0;
            r_lo_found <= 1'b0;
            r_bin0     <= '0;
            r_binl     <= '0;
        end else if ((r_state == ST_P1) && r_s1_vld) begin
            r_total <= total_n;
            if (rep_data != '0) begin
                r_hi <= r_s1_idx;
                if (!r_lo_found) begin
                    r_lo       <= r_s1_idx;
                    r_lo_found <= 1'b1;
                end
            end
            if (r_s1_idx == '0) begin
                r_bin0 <= rep_data;
            end
            if (r_s1_idx == LAST_IDX) begin
                r_binl  <= rep_data;
                r_empty <= (total_n == '0);
            end
        end

        if ((n_state == ST_P2) && (r_state != ST_P2)) begin
            r_run       <= '0;
            r_med       <= '0;
            r_med_found <= 1'b0;
        end else if ((r_state == ST_P2) && r_s1_vld) begin
            r_run <= run_n;
            if (!r_med_found && (run_n >= (r_total >> 1))) begin
                r_med       <= r_s1_idx;
                r_med_found <= 1'b1;
            end
        end

        if ((n_state == ST_P3) && (r_state != ST_P3)) begin
            r_dev <= '0;
        end else if ((r_state == ST_P3) && r_s2_vld) begin
            r_dev <= dev_sum[DEV_W] ? '1 : dev_sum[DEV_W-1:0];
        end

        if ((r_state == ST_ROOT) && root_done) begin
            r_spread <= root_spread;
        end
        if (r_state == ST_OUT) begin
            r_chan <= r_chan + 2'd1;
        end
    end

    always_comb begin
        busy                     = (r_state != ST_IDLE);
        o_result.channel         = r_chan;
        o_result.median_bin      = r_empty ? 8'd0 : 8'(r_med);
        o_result.spread_q8       = r_empty ? 16'd0 : r_spread;
        o_result.lowest_bin      = 8'(r_lo);
        o_result.highest_bin     = 8'(r_hi);
        o_result.dark_count      = 24'(r_bin0);
        o_result.saturated_count = 24'(r_binl);
        o_result.empty_res       = r_empty;
        o_result.last            = (r_chan == r_last_chan);
    end

endmodule

// ===== rtl/core/roi_hist_chk.sv =====
// ---------------------------------------------------------------------------
// roi_hist_chk
// Port-level checks of the histogram block, bound to the top level.
// ---------------------------------------------------------------------------
`include "roi_pixel_histogram_stats_top_assert.svh"

module roi_hist_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input roi_hist_pkg::t_request i_request,
    input logic                   o_done,
    input roi_hist_pkg::t_result  o_result
);
    import roi_hist_pkg::*;

    logic report_acc;
    logic empty_ok;

    assign report_acc = start && !busy && (i_request.command == CMD_REPORT);
    assign empty_ok   = (o_result.spread_q8 == 16'd0) && (o_result.median_bin == 8'd0);

    `RPH_ASSERT_SAME(a_done_busy, i_clk, i_rst_n, o_done, busy)
    `RPH_ASSERT_NEXT(a_report_busy, i_clk, i_rst_n, report_acc, busy)
    `RPH_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `RPH_ASSERT_SAME(a_empty_zero, i_clk, i_rst_n, o_done && o_result.empty_res, empty_ok)
    `RPH_ASSERT_SAME(a_chan_range, i_clk, i_rst_n, o_done, o_result.channel != 2'd3)

endmodule

bind roi_pixel_histogram_stats_top roi_hist_chk u_roi_hist_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_request (i_request),
    .o_done    (o_done),
    .o_result  (o_result)
);
